@@ rtl/rps_pkg.sv @@
`default_nettype none
package rps_pkg;

    // default sizing of the value table
    localparam int CAPACITY_DEF   = 8192;
    localparam int VALUE_BITS_DEF = 16;

    // fixed field widths
    localparam int RAND_BITS  = 31;
    localparam int DIV_CNT_W  = $clog2(RAND_BITS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_VAL_W  = 16;
    localparam int COPY_W     = 4;
    localparam int SPAN_W     = CFG_VAL_W + 1;
    localparam int TOTAL_W    = SPAN_W + COPY_W;
    localparam int OUT_VAL_W  = 16;
    localparam int OUT_POS_W  = 13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_VALUE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_COPIES = 2'd2;

    // configuration reset values
    localparam logic [CFG_VAL_W-1:0] FIRST_RESET  = 16'd1;
    localparam logic [CFG_VAL_W-1:0] LAST_RESET   = 16'd5000;
    localparam logic [COPY_W-1:0]    COPIES_RESET = 4'd0;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FILL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_WR_POS,
        ST_WR_OTH,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

@@ rtl/rps_ram.sv @@
`default_nettype none
module rps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/rps_div.sv @@
`default_nettype none
module rps_div #(
    parameter int DIVISOR_W = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rps_pkg::RAND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]          divisor,
    output logic                               done,
    output logic      [DIVISOR_W-1:0]          remainder
);

    import rps_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAND_BITS-1:0]  dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;
    logic [DIVISOR_W-1:0]  rem_step;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[RAND_BITS-1]};
        diff     = shifted - {1'b0, dsr_reg};
        fits     = shifted >= {1'b0, dsr_reg};
        rem_step = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            dvd_next = {dvd_reg[RAND_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(RAND_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ rtl/random_permutation_shuffle_unit.sv @@
// One word at a time: the input stays closed until the result enters the output register.
// The pace is set by the bit-serial 31-step remainder unit plus the table read and swap, and an output stall holds it.
// The first word of a run adds a setup state and a table fill of n entries (one entry per cycle).
// An empty sequence skips the table fill and goes from setup straight to its result.
// Reset (rst_n, async, active low) restores the register defaults and starts a new run;
// the table itself is not cleared, it is refilled at every run start.
`default_nettype none
module random_permutation_shuffle_unit #(
    parameter int CAPACITY   = rps_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = rps_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [rps_pkg::RAND_BITS-1:0]  random_word,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [rps_pkg::OUT_VAL_W-1:0]  value,
    output logic      [rps_pkg::OUT_POS_W-1:0]  position,
    output logic                                last_of_run,
    output logic                                empty_run,
    output logic                                clipped
);

    import rps_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // configuration registers
    logic [CFG_VAL_W-1:0] cfg_first_reg;
    logic [CFG_VAL_W-1:0] cfg_last_reg;
    logic [COPY_W-1:0]    cfg_copies_reg;

    // control state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                clipped_reg, clipped_next;
    logic                empty_reg, empty_next;
    logic                out_valid_reg, out_valid_next;

    // datapath state
    logic [SPAN_W-1:0]     span_reg, span_next;
    logic [ADDR_W-1:0]     fill_ptr_reg, fill_ptr_next;
    logic [SPAN_W-1:0]     k_reg, k_next;
    logic [RAND_BITS-1:0]  rand_reg, rand_next;
    logic [ADDR_W-1:0]     other_reg, other_next;
    logic [VALUE_BITS-1:0] val_pos_reg, val_pos_next;
    logic [VALUE_BITS-1:0] val_oth_reg, val_oth_next;
    logic [OUT_VAL_W-1:0]  value_reg, value_next;
    logic [OUT_POS_W-1:0]  position_reg, position_next;
    logic                  last_reg, last_next;
    logic                  empty_out_reg, empty_out_next;
    logic                  clipped_out_reg, clipped_out_next;

    // table port
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    // remainder unit
    logic                  div_start;
    logic                  div_done;
    logic [CNT_W-1:0]      div_divisor;
    logic [CNT_W-1:0]      div_rem;

    // helpers
    logic [SPAN_W-1:0]     span_calc;
    logic [COPY_W:0]       copies_p1;
    logic [TOTAL_W-1:0]    total_calc;
    logic                  clip_calc;
    logic [CNT_W-1:0]      n_calc;
    logic [31:0]           fill_sum;
    logic [CNT_W-1:0]      other_calc;
    logic                  fill_done;
    logic                  last_step;
    logic [31:0]           val_wide;
    logic [31:0]           pos_wide;

    // configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_first_reg  <= FIRST_RESET;
            cfg_last_reg   <= LAST_RESET;
            cfg_copies_reg <= COPIES_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIRST_VALUE:  cfg_first_reg  <= cfg_data[CFG_VAL_W-1:0];
                CFG_LAST_VALUE:   cfg_last_reg   <= cfg_data[CFG_VAL_W-1:0];
                CFG_EXTRA_COPIES: cfg_copies_reg <= cfg_data[COPY_W-1:0];
                default:          ;
            endcase
        end
    end

    // run length from the registers
    always_comb
    begin
        span_calc  = (cfg_last_reg >= cfg_first_reg)
                   ? SPAN_W'(cfg_last_reg) - SPAN_W'(cfg_first_reg) + SPAN_W'(1)
                   : '0;
        copies_p1  = {1'b0, cfg_copies_reg} + (COPY_W + 1)'(1);
        total_calc = TOTAL_W'(span_calc) * TOTAL_W'(copies_p1);
        clip_calc  = 32'(total_calc) > 32'(CAPACITY);
        n_calc     = clip_calc ? CNT_W'(CAPACITY) : CNT_W'(total_calc);
    end

    // step arithmetic
    always_comb
    begin
        fill_sum    = 32'(cfg_first_reg) + 32'(k_reg);
        div_divisor = n_reg - CNT_W'(step_reg);
        other_calc  = CNT_W'(step_reg) + div_rem;
        fill_done   = (CNT_W'(fill_ptr_reg) + CNT_W'(1)) == n_reg;
        last_step   = (CNT_W'(step_reg) + CNT_W'(1)) == n_reg;
        val_wide    = 32'(val_oth_reg);
        pos_wide    = 32'(step_reg);
    end

    // sequencer: next state, table accesses and result word
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        n_next           = n_reg;
        clipped_next     = clipped_reg;
        empty_next       = empty_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        span_next        = span_reg;
        fill_ptr_next    = fill_ptr_reg;
        k_next           = k_reg;
        rand_next        = rand_reg;
        other_next       = other_reg;
        val_pos_next     = val_pos_reg;
        val_oth_next     = val_oth_reg;
        value_next       = value_reg;
        position_next    = position_reg;
        last_next        = last_reg;
        empty_out_next   = empty_out_reg;
        clipped_out_next = clipped_out_reg;
        in_ready         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = fill_ptr_reg;
        ram_wdata        = fill_sum[VALUE_BITS-1:0];
        ram_re           = 1'b0;
        ram_raddr        = step_reg;
        div_start        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    rand_next  = random_word;
                    empty_next = 1'b0;
                    state_next = (step_reg == '0) ? ST_SETUP : ST_DIV_START;
                end
            end

            // sample the registers for a new run
            ST_SETUP:
            begin
                span_next     = span_calc;
                n_next        = n_calc;
                clipped_next  = clip_calc;
                fill_ptr_next = '0;
                k_next        = '0;
                if (n_calc == '0)
                begin
                    empty_next = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end

            // load the initial sequence, one entry per cycle
            ST_FILL:
            begin
                ram_we        = 1'b1;
                fill_ptr_next = fill_ptr_reg + ADDR_W'(1);
                k_next        = (k_reg == span_reg - SPAN_W'(1)) ? '0 : k_reg + SPAN_W'(1);
                if (fill_done)
                begin
                    state_next = ST_DIV_START;
                end
            end

            // launch the remainder and fetch the current position
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                ram_re     = 1'b1;
                ram_raddr  = step_reg;
                state_next = ST_DIV_WAIT;
            end

            // remainder ready: keep the current entry, fetch the partner
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    val_pos_next = ram_rdata;
                    other_next   = other_calc[ADDR_W-1:0];
                    ram_re       = 1'b1;
                    ram_raddr    = other_calc[ADDR_W-1:0];
                    state_next   = ST_WR_POS;
                end
            end

            // partner value settles at the current position
            ST_WR_POS:
            begin
                ram_we       = 1'b1;
                ram_waddr    = step_reg;
                ram_wdata    = ram_rdata;
                val_oth_next = ram_rdata;
                state_next   = ST_WR_OTH;
            end

            ST_WR_OTH:
            begin
                ram_we     = 1'b1;
                ram_waddr  = other_reg;
                ram_wdata  = val_pos_reg;
                state_next = ST_EMIT;
            end

            // hand the word to the output register once it is free
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (empty_reg)
                    begin
                        value_next       = '0;
                        position_next    = '0;
                        last_next        = 1'b1;
                        empty_out_next   = 1'b1;
                        clipped_out_next = 1'b0;
                    end
                    else
                    begin
                        value_next       = val_wide[OUT_VAL_W-1:0];
                        position_next    = pos_wide[OUT_POS_W-1:0];
                        last_next        = last_step;
                        empty_out_next   = 1'b0;
                        clipped_out_next = clipped_reg;
                        step_next        = last_step ? '0 : step_reg + ADDR_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            n_reg         <= '0;
            clipped_reg   <= 1'b0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            n_reg         <= n_next;
            clipped_reg   <= clipped_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        span_reg        <= span_next;
        fill_ptr_reg    <= fill_ptr_next;
        k_reg           <= k_next;
        rand_reg        <= rand_next;
        other_reg       <= other_next;
        val_pos_reg     <= val_pos_next;
        val_oth_reg     <= val_oth_next;
        value_reg       <= value_next;
        position_reg    <= position_next;
        last_reg        <= last_next;
        empty_out_reg   <= empty_out_next;
        clipped_out_reg <= clipped_out_next;
    end

    // value table
    rps_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // random word modulo remaining count
    rps_div #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rand_reg),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign position    = position_reg;
    assign last_of_run = last_reg;
    assign empty_run   = empty_out_reg;
    assign clipped     = clipped_out_reg;

endmodule
`default_nettype wire

@@ rtl/rps_checker.sv @@
`default_nettype none
module rps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] value,
    input wire logic [12:0] position,
    input wire logic        last_of_run,
    input wire logic        empty_run,
    input wire logic        clipped
);

    // one word in flight: input closes right after acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after a word was accepted");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(position)
            && $stable(last_of_run) && $stable(empty_run) && $stable(clipped))
        else $error("stalled result changed");

    // empty run word carries fixed fields
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_run |-> last_of_run && !clipped && value == 16'd0
            && position == 13'd0)
        else $error("malformed empty run word");

    // a new result appears together with the input reopening
    a_result_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result shown while input still closed");

endmodule

bind random_permutation_shuffle_unit rps_checker u_rps_checker (.*);
`default_nettype wire
